### hw/rtl/pctbl_pkg.sv
// Shared types, constants and helper functions of the per-client token bucket limiter.
package pctbl_pkg;

    localparam int CLIENT_SLOTS = 4096;
    localparam int SLOT_W       = $clog2(CLIENT_SLOTS);

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SLOT_IN_W = 12;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 16;
    localparam int PROD_W    = TIME_W + CFG_W;

    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAN_SECONDS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CONNECTIONS = 2'd3;

    localparam logic [CFG_W-1:0] RST_BUCKET_CAPACITY = 16'd40;
    localparam logic [CFG_W-1:0] RST_REFILL_RATE     = 16'd10;
    localparam logic [CFG_W-1:0] RST_BAN_SECONDS     = 16'd60;
    localparam logic [CFG_W-1:0] RST_MAX_CONNECTIONS = 16'd50;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] VERDICT_OK         = 2'd0;
    localparam logic [1:0] VERDICT_NEW_BAN    = 2'd1;
    localparam logic [1:0] VERDICT_BANNED     = 2'd2;
    localparam logic [1:0] VERDICT_CONN_LIMIT = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] bucket_capacity;
        logic [CFG_W-1:0] refill_rate;
        logic [CFG_W-1:0] ban_seconds;
        logic [CFG_W-1:0] max_connections;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [CNT_W-1:0]  tokens;
        logic [TIME_W-1:0] refill_stamp;
        logic [CNT_W-1:0]  conn;
        logic [TIME_W-1:0] ban_deadline;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [1:0]       verdict;
        logic [CNT_W-1:0] tokens_left;
        logic [CNT_W-1:0] open_connections;
    } result_t;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } calc_ctrl_t;

    // Reduces a raw slot number modulo the table size. The table size is a power of two,
    // so the reduction keeps the low slot bits.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_IN_W-1:0] raw);
        return SLOT_W'(raw & SLOT_IN_W'(CLIENT_SLOTS - 1));
    endfunction

endpackage

### hw/rtl/pctbl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pctbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/pctbl_calc.sv
// Two-stage update datapath: refill product, saturation and the final verdict.
module pctbl_calc (
    input  logic                      aclk,
    input  pctbl_pkg::calc_ctrl_t     ctrl,
    input  pctbl_pkg::cfg_t           cfg,
    input  logic                      op,
    input  logic [pctbl_pkg::TIME_W-1:0] now,
    input  pctbl_pkg::entry_t         rd_entry,
    output pctbl_pkg::entry_t         wr_entry,
    output pctbl_pkg::result_t        result
);
    import pctbl_pkg::*;

    // Stage one: entry selection, ban check and the refill product.
    entry_t              ent1_reg;
    logic                known1_reg;
    logic                banned1_reg;
    logic                refill1_reg;
    logic                conn_full1_reg;
    logic [PROD_W-1:0]   prod1_reg;

    // Stage two: refilled bucket and the saturated ban deadline.
    entry_t              ent2_reg;
    entry_t              ent2_next;
    logic                known2_reg;
    logic                banned2_reg;
    logic                conn_full2_reg;
    logic [TIME_W-1:0]   until2_reg;

    entry_t              ent_sel;
    logic [TIME_W-1:0]   elapsed;
    logic [PROD_W:0]     sum;
    logic [CNT_W-1:0]    tok_refill;
    logic [TIME_W:0]     until_wide;
    logic                do_refill;

    always_comb begin
        ent_sel = rd_entry;
        if (op == OP_ACQUIRE && !rd_entry.valid) begin
            ent_sel.valid        = 1'b1;
            ent_sel.tokens       = cfg.bucket_capacity;
            ent_sel.refill_stamp = now;
            ent_sel.conn         = '0;
            ent_sel.ban_deadline = '0;
        end
        elapsed = now - rd_entry.refill_stamp;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.s1_en) begin
            ent1_reg       <= ent_sel;
            known1_reg     <= rd_entry.valid;
            banned1_reg    <= ent_sel.ban_deadline > now;
            refill1_reg    <= (op == OP_ACQUIRE) && rd_entry.valid
                              && (now > rd_entry.refill_stamp);
            conn_full1_reg <= ent_sel.conn >= cfg.max_connections;
            prod1_reg      <= elapsed * cfg.refill_rate;
        end
    end

    always_comb begin
        do_refill  = refill1_reg && !banned1_reg;
        sum        = (PROD_W + 1)'(ent1_reg.tokens) + (PROD_W + 1)'(prod1_reg);
        tok_refill = (sum > (PROD_W + 1)'(cfg.bucket_capacity)) ? cfg.bucket_capacity
                                                                : sum[CNT_W-1:0];
        until_wide = (TIME_W + 1)'(now) + (TIME_W + 1)'(cfg.ban_seconds);
        ent2_next  = ent1_reg;
        if (do_refill) begin
            ent2_next.tokens       = tok_refill;
            ent2_next.refill_stamp = now;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.s2_en) begin
            ent2_reg       <= ent2_next;
            known2_reg     <= known1_reg;
            banned2_reg    <= banned1_reg;
            conn_full2_reg <= conn_full1_reg;
            until2_reg     <= until_wide[TIME_W] ? '1 : until_wide[TIME_W-1:0];
        end
    end

    // Final decision on the refilled entry.
    always_comb begin
        wr_entry       = ent2_reg;
        result.verdict = VERDICT_OK;
        if (op == OP_RELEASE) begin
            if (known2_reg && ent2_reg.conn != '0) begin
                wr_entry.conn = ent2_reg.conn - CNT_W'(1);
            end
        end else if (banned2_reg) begin
            result.verdict = VERDICT_BANNED;
        end else if (ent2_reg.tokens == '0) begin
            wr_entry.ban_deadline = until2_reg;
            result.verdict        = VERDICT_NEW_BAN;
        end else if (conn_full2_reg) begin
            result.verdict = VERDICT_CONN_LIMIT;
        end else begin
            wr_entry.tokens = ent2_reg.tokens - CNT_W'(1);
            wr_entry.conn   = ent2_reg.conn + CNT_W'(1);
        end

        if (op == OP_RELEASE && !known2_reg) begin
            result.tokens_left      = '0;
            result.open_connections = '0;
        end else begin
            result.tokens_left      = wr_entry.tokens;
            result.open_connections = wr_entry.conn;
        end
    end

endmodule

### hw/rtl/per_client_token_bucket_limiter_unit.sv
// Top level of the per-client token bucket limiter: sequencer, slot memory and output register.
// A request passes through the read, two compute steps and the write-back; the write-back
// registers its result in the output register and waits while that register is still full.
// A new request is accepted only after the previous one has finished its write-back.
// Reset: synchronous, active low; it restores the register defaults and then runs a clearing
// pass over all CLIENT_SLOTS (4096) entries of the slot memory, during which s_ready stays low.
module per_client_token_bucket_limiter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [pctbl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pctbl_pkg::CFG_W-1:0]       cfg_data,
    // Request channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [pctbl_pkg::SLOT_IN_W-1:0]   s_client_slot,
    input  logic [pctbl_pkg::TIME_W-1:0]      s_now_seconds,
    // Result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_verdict,
    output logic [pctbl_pkg::CNT_W-1:0]       m_tokens_left,
    output logic [pctbl_pkg::CNT_W-1:0]       m_open_connections
);
    import pctbl_pkg::*;

    // One-hot sequencer. Each request walks through read, two compute steps and a
    // write-back; the clearing state runs once after reset.
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_CALC1 = 6'b001000,
        ST_CALC2 = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    cfg_t               cfg_reg;
    logic [SLOT_W-1:0]  clr_reg, clr_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic               op_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               m_valid_reg, m_valid_next;
    result_t            out_reg;

    logic               in_fire;
    logic               out_free;
    logic               commit;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             wr_entry;
    result_t            result;
    calc_ctrl_t         calc_ctrl;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    // The output register can take a new result once the old one has been taken or
    // is being taken in this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_WRITE) && out_free;

    // Configuration registers. Writes must arrive only while the block is idle; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bucket_capacity <= RST_BUCKET_CAPACITY;
            cfg_reg.refill_rate     <= RST_REFILL_RATE;
            cfg_reg.ban_seconds     <= RST_BAN_SECONDS;
            cfg_reg.max_connections <= RST_MAX_CONNECTIONS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BUCKET_CAPACITY: cfg_reg.bucket_capacity <= cfg_data;
                REG_REFILL_RATE:     cfg_reg.refill_rate     <= cfg_data;
                REG_BAN_SECONDS:     cfg_reg.ban_seconds     <= cfg_data;
                REG_MAX_CONNECTIONS: cfg_reg.max_connections <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer next state. A request holds the only slot in flight, so a write-back
    // always lands before the next read and no forwarding path is needed.
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + SLOT_W'(1);
                if (clr_reg == SLOT_W'(CLIENT_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_CALC1;
            ST_CALC1: state_next = ST_CALC2;
            ST_CALC2: state_next = ST_WRITE;
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Request capture. The slot is reduced to the table size on the way in.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            slot_reg <= slot_of(s_client_slot);
            op_reg   <= s_opcode;
            now_reg  <= s_now_seconds;
        end
    end

    // Slot memory: the clearing pass zeroes every entry, which drops its valid bit;
    // afterwards the only writer is the write-back of the request in flight.
    assign ram_we    = (state_reg == ST_CLEAR) || commit;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : slot_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : ENTRY_W'(wr_entry);

    pctbl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CLIENT_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == ST_READ),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign calc_ctrl.s1_en = (state_reg == ST_CALC1);
    assign calc_ctrl.s2_en = (state_reg == ST_CALC2);

    pctbl_calc u_calc (
        .aclk     (aclk),
        .ctrl     (calc_ctrl),
        .cfg      (cfg_reg),
        .op       (op_reg),
        .now      (now_reg),
        .rd_entry (entry_t'(ram_rdata)),
        .wr_entry (wr_entry),
        .result   (result)
    );

    // Output register. It decouples the result channel so that the next request can
    // be accepted while this result still waits for the consumer.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_reg <= result;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_verdict          = out_reg.verdict;
    assign m_tokens_left      = out_reg.tokens_left;
    assign m_open_connections = out_reg.open_connections;

endmodule
